/* design/ufs_pkg.sv */
package ufs_pkg;

    // Element storage
    localparam int MAX_ELEMENTS = 1024;
    localparam int IDX_W        = 10;
    localparam int CNT_W        = 11;

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ELEMENTS);

    // One link entry: a root holds its set size, any other node its parent
    typedef struct packed {
        logic             is_root;
        logic [CNT_W-1:0] value;
    } ufs_entry_t;

    localparam int ENTRY_W = $bits(ufs_entry_t);

    typedef enum logic {
        OP_QUERY = 1'b0,
        OP_UNITE = 1'b1
    } ufs_op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_COMPRESS,
        ST_MERGE,
        ST_LINK,
        ST_DELIVER
    } ufs_state_t;

endpackage

/* design/ufs_in_if.sv */
interface ufs_in_if;

    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [ufs_pkg::IDX_W-1:0] first_index;
    logic [ufs_pkg::IDX_W-1:0] second_index;

    modport source (
        output valid,
        output operation,
        output first_index,
        output second_index,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  first_index,
        input  second_index,
        output ready
    );

endinterface

/* design/ufs_out_if.sv */
interface ufs_out_if;

    logic                      valid;
    logic                      ready;
    logic [ufs_pkg::IDX_W-1:0] root_first;
    logic [ufs_pkg::IDX_W-1:0] root_second;
    logic                      same_set;
    logic [ufs_pkg::CNT_W-1:0] set_size;
    logic [ufs_pkg::CNT_W-1:0] set_count;
    logic                      merged;
    logic                      index_error;

    modport source (
        output valid,
        output root_first,
        output root_second,
        output same_set,
        output set_size,
        output set_count,
        output merged,
        output index_error,
        input  ready
    );

    modport sink (
        input  valid,
        input  root_first,
        input  root_second,
        input  same_set,
        input  set_size,
        input  set_count,
        input  merged,
        input  index_error,
        output ready
    );

endinterface

/* design/union_find_by_size.sv */
// Disjoint-set forest over 1024 elements with union by size and path
// compression. A request beat carries an operation (query or unite) and two
// element indices; each request yields exactly one result beat with both
// roots, a same-set flag, the first element's set size, the set count and a
// merge flag. All links live in one single-port-read RAM, so every find
// walks to the root one hop at a time and then compresses the path one
// hop at a time. A unite that joins two sets then writes the summed size
// to the larger root and links the smaller root under it. Union by size
// keeps the path length of any element at 10 or below. A request with an
// index at or above element_count skips the walk and goes straight to
// delivery. Delivery waits while an earlier result is still held. After
// reset and after every write of element_count the block sweeps all 1024
// entries back to singletons, one per cycle, and accepts no request during
// the sweep. The result is held in an output register, so a new request is
// taken while a finished result waits.
module union_find_by_size (
    input  logic                        clk,
    input  logic                        rst_n,
    ufs_in_if.sink                      request,
    ufs_out_if.source                   result,
    input  logic                        cfg_write,
    input  logic [ufs_pkg::CNT_W-1:0]   cfg_data
);

    localparam int IDX_W   = ufs_pkg::IDX_W;
    localparam int CNT_W   = ufs_pkg::CNT_W;
    localparam int ENTRY_W = ufs_pkg::ENTRY_W;

    // Sequencer and bookkeeping
    ufs_pkg::ufs_state_t state_reg, state_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    sets_reg, sets_next;

    // Item working registers
    logic                op_reg, op_next;
    logic [IDX_W-1:0]    first_reg, first_next;
    logic [IDX_W-1:0]    second_reg, second_next;
    logic                which_reg, which_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [IDX_W-1:0]    root_a_reg, root_a_next;
    logic [IDX_W-1:0]    root_b_reg, root_b_next;
    logic [CNT_W-1:0]    size_a_reg, size_a_next;
    logic [CNT_W-1:0]    size_b_reg, size_b_next;
    logic                merged_reg, merged_next;
    logic                error_reg, error_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    out_root_first_reg, out_root_first_next;
    logic [IDX_W-1:0]    out_root_second_reg, out_root_second_next;
    logic                out_same_reg, out_same_next;
    logic [CNT_W-1:0]    out_size_reg, out_size_next;
    logic [CNT_W-1:0]    out_count_reg, out_count_next;
    logic                out_merged_reg, out_merged_next;
    logic                out_error_reg, out_error_next;

    // Link memory
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    ufs_pkg::ufs_entry_t rd_entry;
    ufs_pkg::ufs_entry_t wr_entry;

    // Helpers
    logic                accept;
    logic                range_bad;
    logic [CNT_W-1:0]    cfg_clamped;
    logic [IDX_W-1:0]    root_cur;
    logic [IDX_W-1:0]    start_idx;
    logic                walk_on;
    logic [IDX_W-1:0]    big_root;
    logic [IDX_W-1:0]    small_root;
    logic [CNT_W-1:0]    size_sum;
    logic                out_free;

    ufs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ufs_pkg::MAX_ELEMENTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = ram_rdata;
    assign ram_wdata = wr_entry;

    // Handshake and decode
    assign request.ready = (state_reg == ufs_pkg::ST_IDLE);
    assign accept        = request.valid && (state_reg == ufs_pkg::ST_IDLE);
    assign range_bad     = ({1'b0, request.first_index} >= count_reg) ||
                           ({1'b0, request.second_index} >= count_reg);
    assign out_free      = !out_valid_reg || result.ready;

    // Current find: its start and its root
    assign root_cur  = which_reg ? root_b_reg : root_a_reg;
    assign start_idx = which_reg ? second_reg : first_reg;
    assign walk_on   = !rd_entry.is_root && (cur_reg != root_cur);

    // Union by size; ties keep the first root
    assign big_root   = (size_b_reg > size_a_reg) ? root_b_reg : root_a_reg;
    assign small_root = (size_b_reg > size_a_reg) ? root_a_reg : root_b_reg;
    assign size_sum   = CNT_W'(size_a_reg + size_b_reg);

    // Count register clamp
    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            cfg_clamped = CNT_W'(1);
        end
        else if (cfg_data > ufs_pkg::MAX_COUNT)
        begin
            cfg_clamped = ufs_pkg::MAX_COUNT;
        end
        else
        begin
            cfg_clamped = cfg_data;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ufs_pkg::ST_CLEAR:
            begin
                if (clr_reg == IDX_W'(ufs_pkg::MAX_ELEMENTS - 1))
                begin
                    state_next = ufs_pkg::ST_IDLE;
                end
            end
            ufs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = range_bad ? ufs_pkg::ST_DELIVER : ufs_pkg::ST_WALK;
                end
            end
            ufs_pkg::ST_WALK:
            begin
                if (rd_entry.is_root)
                begin
                    state_next = ufs_pkg::ST_COMPRESS;
                end
            end
            ufs_pkg::ST_COMPRESS:
            begin
                if (!walk_on)
                begin
                    if (!which_reg)
                    begin
                        state_next = ufs_pkg::ST_WALK;
                    end
                    else if (op_reg == ufs_pkg::OP_UNITE && root_a_reg != root_b_reg)
                    begin
                        state_next = ufs_pkg::ST_MERGE;
                    end
                    else
                    begin
                        state_next = ufs_pkg::ST_DELIVER;
                    end
                end
            end
            ufs_pkg::ST_MERGE:
            begin
                state_next = ufs_pkg::ST_LINK;
            end
            ufs_pkg::ST_LINK:
            begin
                state_next = ufs_pkg::ST_DELIVER;
            end
            ufs_pkg::ST_DELIVER:
            begin
                if (out_free)
                begin
                    state_next = ufs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ufs_pkg::ST_CLEAR;
            end
        endcase
        // A count write restarts the clearing sweep
        if (cfg_write)
        begin
            state_next = ufs_pkg::ST_CLEAR;
        end
    end

    // Datapath and memory control
    always_comb
    begin
        clr_next             = clr_reg;
        count_next           = count_reg;
        sets_next            = sets_reg;
        op_next              = op_reg;
        first_next           = first_reg;
        second_next          = second_reg;
        which_next           = which_reg;
        cur_next             = cur_reg;
        root_a_next          = root_a_reg;
        root_b_next          = root_b_reg;
        size_a_next          = size_a_reg;
        size_b_next          = size_b_reg;
        merged_next          = merged_reg;
        error_next           = error_reg;
        out_valid_next       = out_valid_reg && !result.ready;
        out_root_first_next  = out_root_first_reg;
        out_root_second_next = out_root_second_reg;
        out_same_next        = out_same_reg;
        out_size_next        = out_size_reg;
        out_count_next       = out_count_reg;
        out_merged_next      = out_merged_reg;
        out_error_next       = out_error_reg;
        ram_we               = 1'b0;
        ram_waddr            = cur_reg;
        ram_raddr            = cur_reg;
        wr_entry             = '0;

        unique case (state_reg)
            ufs_pkg::ST_CLEAR:
            begin
                ram_we           = 1'b1;
                ram_waddr        = clr_reg;
                wr_entry.is_root = 1'b1;
                wr_entry.value   = CNT_W'(1);
                clr_next         = clr_reg + IDX_W'(1);
            end
            ufs_pkg::ST_IDLE:
            begin
                ram_raddr = request.first_index;
                if (accept)
                begin
                    op_next     = request.operation;
                    first_next  = request.first_index;
                    second_next = request.second_index;
                    cur_next    = request.first_index;
                    which_next  = 1'b0;
                    merged_next = 1'b0;
                    error_next  = range_bad;
                end
            end
            ufs_pkg::ST_WALK:
            begin
                // One hop per cycle toward the root
                if (rd_entry.is_root)
                begin
                    if (which_reg)
                    begin
                        root_b_next = cur_reg;
                        size_b_next = rd_entry.value;
                    end
                    else
                    begin
                        root_a_next = cur_reg;
                        size_a_next = rd_entry.value;
                    end
                    ram_raddr = start_idx;
                    cur_next  = start_idx;
                end
                else
                begin
                    ram_raddr = rd_entry.value[IDX_W-1:0];
                    cur_next  = rd_entry.value[IDX_W-1:0];
                end
            end
            ufs_pkg::ST_COMPRESS:
            begin
                // Repoint the node just read at the root, fetch its old parent
                if (walk_on)
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = cur_reg;
                    wr_entry.is_root = 1'b0;
                    wr_entry.value   = CNT_W'(root_cur);
                    ram_raddr        = rd_entry.value[IDX_W-1:0];
                    cur_next         = rd_entry.value[IDX_W-1:0];
                end
                else if (!which_reg)
                begin
                    which_next = 1'b1;
                    ram_raddr  = second_reg;
                    cur_next   = second_reg;
                end
            end
            ufs_pkg::ST_MERGE:
            begin
                ram_we           = 1'b1;
                ram_waddr        = big_root;
                wr_entry.is_root = 1'b1;
                wr_entry.value   = size_sum;
                sets_next        = sets_reg - CNT_W'(1);
                merged_next      = 1'b1;
            end
            ufs_pkg::ST_LINK:
            begin
                ram_we           = 1'b1;
                ram_waddr        = small_root;
                wr_entry.is_root = 1'b0;
                wr_entry.value   = CNT_W'(big_root);
            end
            ufs_pkg::ST_DELIVER:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_count_next  = sets_reg;
                    out_error_next  = error_reg;
                    out_merged_next = merged_reg && !error_reg;
                    priority if (error_reg)
                    begin
                        out_root_first_next  = '0;
                        out_root_second_next = '0;
                        out_same_next        = 1'b0;
                        out_size_next        = '0;
                    end
                    else if (merged_reg)
                    begin
                        out_root_first_next  = big_root;
                        out_root_second_next = big_root;
                        out_same_next        = 1'b1;
                        out_size_next        = size_sum;
                    end
                    else
                    begin
                        out_root_first_next  = root_a_reg;
                        out_root_second_next = root_b_reg;
                        out_same_next        = (root_a_reg == root_b_reg);
                        out_size_next        = size_a_reg;
                    end
                end
            end
            default:
            begin
                clr_next = '0;
            end
        endcase

        if (cfg_write)
        begin
            count_next = cfg_clamped;
            sets_next  = cfg_clamped;
            clr_next   = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ufs_pkg::ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= ufs_pkg::MAX_COUNT;
            sets_reg      <= ufs_pkg::MAX_COUNT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            sets_reg      <= sets_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg              <= op_next;
        first_reg           <= first_next;
        second_reg          <= second_next;
        which_reg           <= which_next;
        cur_reg             <= cur_next;
        root_a_reg          <= root_a_next;
        root_b_reg          <= root_b_next;
        size_a_reg          <= size_a_next;
        size_b_reg          <= size_b_next;
        merged_reg          <= merged_next;
        error_reg           <= error_next;
        out_root_first_reg  <= out_root_first_next;
        out_root_second_reg <= out_root_second_next;
        out_same_reg        <= out_same_next;
        out_size_reg        <= out_size_next;
        out_count_reg       <= out_count_next;
        out_merged_reg      <= out_merged_next;
        out_error_reg       <= out_error_next;
    end

    // Result beat
    assign result.valid       = out_valid_reg;
    assign result.root_first  = out_root_first_reg;
    assign result.root_second = out_root_second_reg;
    assign result.same_set    = out_same_reg;
    assign result.set_size    = out_size_reg;
    assign result.set_count   = out_count_reg;
    assign result.merged      = out_merged_reg;
    assign result.index_error = out_error_reg;

    // Checks
    a_sets_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        sets_reg != '0 && sets_reg <= count_reg)
        else $error("set count out of bounds");

    a_compress_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ufs_pkg::ST_COMPRESS && ram_we) |-> ram_waddr != ram_raddr)
        else $error("path compression reads and writes one entry");

    a_merge_joins: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.merged) |->
            (result.same_set && result.root_first == result.root_second))
        else $error("merged result with distinct roots");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.index_error) |->
            (!result.merged && !result.same_set && result.set_size == '0))
        else $error("index error result carries data");

endmodule

/* design/ufs_ram.sv */
module ufs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
